/* src/piq_pkg.sv */
// ----------------------------------------------------------------------------
// piq_pkg
// Shared types and codes for the positional insert queue.
// ----------------------------------------------------------------------------
package piq_pkg;

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam int unsigned NAME_W  = 64;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE
  } op_t;

  typedef struct packed {
    logic take;
    op_t  op;
  } cmd_t;

endpackage

/* src/piq_ctrl.sv */
// ----------------------------------------------------------------------------
// piq_ctrl
// Controller: handshakes, held count, insert index and result status.
// ----------------------------------------------------------------------------
module piq_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_kind,
  input  logic [7:0]                in_position,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_status,
  output logic [4:0]                out_count,
  output logic                      out_is_empty,
  output piq_pkg::cmd_t             cmd,
  output logic [$clog2(DEPTH)-1:0]  ins_idx
);
  import piq_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > 8) ? CNT_W : 8;

  typedef enum logic {
    S_EMPTY,
    S_HOLD
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [4:0]        ocount_r;
  logic              oempty_r;
  logic              accept;
  logic              full;
  logic [CMP_W-1:0]  pos_eff;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CMP_W-1:0]  idx_ext;
  op_t               op;

  assign in_stall     = (state_r == S_HOLD) && out_stall;
  assign accept       = in_valid && !in_stall;
  assign out_valid    = (state_r == S_HOLD);
  assign out_status   = status_r;
  assign out_count    = ocount_r;
  assign out_is_empty = oempty_r;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign cnt_ext = CMP_W'(count_r);
  assign pos_eff = (in_position == 8'd0) ? CMP_W'(1) : CMP_W'(in_position);

  always_comb begin
    idx_ext = cnt_ext;
    if (in_kind == KIND_INSERT && pos_eff <= cnt_ext) begin
      idx_ext = pos_eff - CMP_W'(1);
    end
  end
  assign ins_idx = idx_ext[IDX_W-1:0];

  always_comb begin
    op         = OP_NONE;
    status_nxt = STATUS_DONE;
    count_nxt  = count_r;
    case (in_kind)
      KIND_APPEND, KIND_INSERT: begin
        if (full) begin
          status_nxt = STATUS_FULL;
        end else begin
          op        = OP_INSERT;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      KIND_REMOVE: begin
        if (count_r == '0) begin
          status_nxt = STATUS_EMPTY;
        end else begin
          op        = OP_REMOVE;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: op = OP_NONE;
    endcase
  end

  assign cmd.take = accept;
  assign cmd.op   = accept ? op : OP_NONE;

  always_comb begin
    state_nxt = state_r;
    if (accept) begin
      state_nxt = S_HOLD;
    end else if (state_r == S_HOLD && !out_stall) begin
      state_nxt = S_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_EMPTY;
      count_r  <= '0;
      status_r <= STATUS_DONE;
      ocount_r <= '0;
      oempty_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        count_r  <= count_nxt;
        status_r <= status_nxt;
        ocount_r <= 5'(count_nxt);
        oempty_r <= (count_nxt == '0);
      end
    end
  end

endmodule

/* src/piq_datapath.sv */
// ----------------------------------------------------------------------------
// piq_datapath
// Shift-register cell chain holding the records, plus the result registers.
// ----------------------------------------------------------------------------
module piq_datapath #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned NAME_BYTES = 8
) (
  input  logic                      clk,
  input  piq_pkg::cmd_t             cmd,
  input  logic [$clog2(DEPTH)-1:0]  ins_idx,
  input  logic [63:0]               in_name_tag,
  input  logic signed [31:0]        in_value,
  output logic [63:0]               out_name_tag,
  output logic signed [31:0]        out_value
);
  import piq_pkg::*;

  localparam int unsigned TAG_W = 8 * NAME_BYTES;

  logic [TAG_W-1:0]    tag_r [DEPTH];
  logic [VALUE_W-1:0]  val_r [DEPTH];
  logic [NAME_W-1:0]   otag_r;
  logic [VALUE_W-1:0]  oval_r;

  assign out_name_tag = otag_r;
  assign out_value    = signed'(oval_r);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_ff @(posedge clk) begin
      case (cmd.op)
        OP_INSERT: begin
          if (i == int'(ins_idx)) begin
            tag_r[i] <= in_name_tag[TAG_W-1:0];
            val_r[i] <= in_value;
          end else if (i > int'(ins_idx)) begin
            tag_r[i] <= tag_r[(i > 0) ? i - 1 : 0];
            val_r[i] <= val_r[(i > 0) ? i - 1 : 0];
          end
        end
        OP_REMOVE: begin
          if (i < DEPTH - 1) begin
            tag_r[i] <= tag_r[(i < DEPTH - 1) ? i + 1 : i];
            val_r[i] <= val_r[(i < DEPTH - 1) ? i + 1 : i];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (cmd.op == OP_REMOVE) begin
        otag_r <= NAME_W'(tag_r[0]);
        oval_r <= val_r[0];
      end else begin
        otag_r <= '0;
        oval_r <= '0;
      end
    end
  end

endmodule

/* src/positional_insert_queue.sv */
// ----------------------------------------------------------------------------
// positional_insert_queue
// Ordered record queue with append, positional insert and head remove.
// ----------------------------------------------------------------------------
// Each operation is carried out in a shift-register cell chain: every cell
// loads from itself, its neighbor or the input at once. One item is accepted
// per cycle while the result register is free or being drained; a result is
// held in a single output register, so a stalled output stalls the input.
// Every item yields exactly one result with status, count and empty flag.
module positional_insert_queue #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned NAME_BYTES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [63:0]        in_name_tag,
  input  logic signed [31:0] in_value,
  input  logic [7:0]         in_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        out_name_tag,
  output logic signed [31:0] out_value,
  output logic [1:0]         out_status,
  output logic [4:0]         out_count,
  output logic               out_is_empty
);
  import piq_pkg::*;

  cmd_t                      cmd;
  logic [$clog2(DEPTH)-1:0]  ins_idx;

  piq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_position  (in_position),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_count    (out_count),
    .out_is_empty (out_is_empty),
    .cmd          (cmd),
    .ins_idx      (ins_idx)
  );

  piq_datapath #(
    .DEPTH      (DEPTH),
    .NAME_BYTES (NAME_BYTES)
  ) u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .ins_idx      (ins_idx),
    .in_name_tag  (in_name_tag),
    .in_value     (in_value),
    .out_name_tag (out_name_tag),
    .out_value    (out_value)
  );

endmodule
